// ===== rtl/radix2_complex_fft_defines.svh =====
// assertion macros used by the fft back end
`ifndef RADIX2_COMPLEX_FFT_DEFINES_SVH
`define RADIX2_COMPLEX_FFT_DEFINES_SVH
`ifndef SYNTH
`define RFFT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RFFT_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RFFT_CHECK(lbl, prop, msg)
`define RFFT_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/rfft_pkg.sv =====
// shared constants, types and twiddle rom builder of the fft
package rfft_pkg;

  localparam int MAX_LOG2_LENGTH = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int TWIDDLE_BITS    = 18;
  localparam int LOG2_RESET      = 10;

  localparam int WORK_BITS  = 48;
  localparam int FRAC_BITS  = 16;
  localparam int LO_BITS    = 24;
  localparam int HI_BITS    = WORK_BITS - LO_BITS;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOG2_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIRECTION   = 1'b1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam longint unsigned PI2_Q30 = 64'd6746518852;

  typedef struct packed {
    logic valid;
    logic load;
  } queue_ctl_t;

  // one taylor term divided by (2n)(2n+1), fixed divisors per term
  function automatic longint unsigned taylor_div(input longint unsigned v,
                                                 input int unsigned n);
    case (n)
      1:       return v / 64'd6;
      2:       return v / 64'd20;
      3:       return v / 64'd42;
      4:       return v / 64'd72;
      5:       return v / 64'd110;
      6:       return v / 64'd156;
      7:       return v / 64'd210;
      default: return v;
    endcase
  endfunction

  // sin(2 pi j / 2^tw_log2) from an integer taylor series in q30
  function automatic longint unsigned sine_value(input int unsigned j,
                                                 input int unsigned tw_log2,
                                                 input int unsigned tw_frac);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          sum;
    int unsigned     sh;
    int unsigned     n;
    x    = (PI2_Q30 * longint'(j) + (64'd1 << (tw_log2 - 1))) >> tw_log2;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 7; n++) begin
      term = taylor_div((term * x2 + (64'd1 << 29)) >> 30, n);
      if (n[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    q = longint'(sum);
    if (tw_frac < 30) begin
      sh = 30 - tw_frac;
      q  = (q + (64'd1 << (sh - 1))) >> sh;
    end else begin
      q = q << (tw_frac - 30);
    end
    return q;
  endfunction

endpackage

// ===== rtl/rfft_if.sv =====
// input and output channel interfaces of the fft
interface rfft_in_if #(
  parameter int SAMPLE_BITS = rfft_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [SAMPLE_BITS-1:0] real_in;
  logic signed [SAMPLE_BITS-1:0] imag_in;

  modport source (output valid, action, real_in, imag_in, input ready);
  modport sink   (input valid, action, real_in, imag_in, output ready);
endinterface

interface rfft_out_if #(
  parameter int OUT_BITS = rfft_pkg::SAMPLE_BITS + rfft_pkg::MAX_LOG2_LENGTH + 1,
  parameter int IDX_BITS = rfft_pkg::MAX_LOG2_LENGTH
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] real_out;
  logic signed [OUT_BITS-1:0] imag_out;
  logic [IDX_BITS-1:0]        bin_index;
  logic                       last_out;

  modport source (output valid, real_out, imag_out, bin_index, last_out, input ready);
  modport sink   (input valid, real_out, imag_out, bin_index, last_out, output ready);
endinterface

// ===== rtl/rfft_front.sv =====
// front end: takes input items, tags load or drain, and queues them
module rfft_front #(
  parameter int SAMPLE_BITS = rfft_pkg::SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  rfft_in_if.sink                       in_ch,
  output rfft_pkg::queue_ctl_t          q_ctl,
  output logic signed [SAMPLE_BITS-1:0] q_re,
  output logic signed [SAMPLE_BITS-1:0] q_im,
  input  logic                          q_pop
);

  localparam int PTR_W = $clog2(rfft_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rfft_pkg::QUEUE_DEPTH + 1);

  logic                          ent_load [rfft_pkg::QUEUE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] ent_re   [rfft_pkg::QUEUE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] ent_im   [rfft_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]              wr_ptr;
  logic [PTR_W-1:0]              rd_ptr;
  logic [CNT_W-1:0]              count;
  logic                          push;

  assign in_ch.ready = (count != CNT_W'(rfft_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)  wr_ptr <= wr_ptr + PTR_W'(1);
      if (q_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !q_pop)      count <= count + CNT_W'(1);
      else if (!push && q_pop) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_load[wr_ptr] <= (in_ch.action == rfft_pkg::ACT_LOAD);
      ent_re[wr_ptr]   <= in_ch.real_in;
      ent_im[wr_ptr]   <= in_ch.imag_in;
    end
  end

  assign q_ctl.valid = (count != '0);
  assign q_ctl.load  = ent_load[rd_ptr];
  assign q_re        = ent_re[rd_ptr];
  assign q_im        = ent_im[rd_ptr];

endmodule

// ===== rtl/rfft_back.sv =====
// back end: sample memory, butterfly engine and result output register
`include "radix2_complex_fft_defines.svh"
module rfft_back #(
  parameter int MAX_LOG2_LENGTH = rfft_pkg::MAX_LOG2_LENGTH,
  parameter int SAMPLE_BITS     = rfft_pkg::SAMPLE_BITS,
  parameter int TWIDDLE_BITS    = rfft_pkg::TWIDDLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rfft_pkg::queue_ctl_t               q_ctl,
  input  logic signed [SAMPLE_BITS-1:0]      q_re,
  input  logic signed [SAMPLE_BITS-1:0]      q_im,
  output logic                               q_pop,
  input  logic                               cfg_we,
  input  logic [rfft_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rfft_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  rfft_out_if.source                         out_ch
);

  localparam int MX      = MAX_LOG2_LENGTH;
  localparam int LGW     = $clog2(MX + 1);
  localparam int WB      = rfft_pkg::WORK_BITS;
  localparam int FB      = rfft_pkg::FRAC_BITS;
  localparam int LO      = rfft_pkg::LO_BITS;
  localparam int HI      = rfft_pkg::HI_BITS;
  localparam int AW      = MX + 1;
  localparam int DEPTH   = 2 ** AW;
  localparam int TW_LOG2 = (MX < 2) ? 2 : MX;
  localparam int TW_Q    = 2 ** (TW_LOG2 - 2);
  localparam int RA_W    = TW_LOG2 - 1;
  localparam int TW_FRAC = TWIDDLE_BITS - 1;
  localparam int TWW     = TWIDDLE_BITS + 1;
  localparam int OB      = SAMPLE_BITS + MX + 1;
  localparam int R_W     = WB - FB + 1;
  localparam int SAT_W   = (R_W > OB) ? R_W : OB;
  localparam int LG_RST  = (MX < rfft_pkg::LOG2_RESET) ? MX : rfft_pkg::LOG2_RESET;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_MUL  = 6'b000100,
    S_SUM  = 6'b001000,
    S_WA   = 6'b010000,
    S_WB   = 6'b100000
  } state_t;

  state_t            state;
  logic [LGW-1:0]    lg;
  logic              dir;
  logic [LGW-1:0]    fr_lg;
  logic              fr_dir;
  logic              wb;
  logic              res_bank;
  logic [MX:0]       load_count;
  logic [MX-1:0]     read_index;
  logic [MX:0]       pending;
  logic [LGW-1:0]    st;
  logic [MX-1:0]     bf;
  logic              emit_pend;
  logic [MX-1:0]     emit_idx;
  logic              emit_last;
  logic              out_valid;

  logic              do_read;
  logic              do_load;
  logic              frame_done;
  logic              last_bf;
  logic              last_st;
  logic [MX:0]       n_cfg;
  logic [MX:0]       n_fr;
  logic [MX-1:0]     half_m1;
  logic [MX-1:0]     lo_mask;
  logic [MX-1:0]     bi;
  logic [MX-1:0]     bk;
  logic [MX-1:0]     rev;
  logic [MX-1:0]     ld_pos;
  logic [LGW-1:0]    cfg_lg;

  // ---------------- sample memory: two banks of complex words ----------------
  logic [2*WB-1:0]   mem [DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [2*WB-1:0]   mem_wdata;
  logic [AW-1:0]     raddr_a;
  logic [AW-1:0]     raddr_b;
  logic [2*WB-1:0]   rd_a;
  logic [2*WB-1:0]   rd_b;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // ---------------- twiddle rom ----------------
  logic [TWIDDLE_BITS-1:0] sine_rom [TW_Q + 1];
  logic [TW_LOG2-1:0]      tw_full;
  logic [RA_W-1:0]         tw_idx;
  logic signed [TWW-1:0]   tw_c;
  logic signed [TWW-1:0]   tw_s;

  for (genvar j = 0; j <= TW_Q; j++) begin : g_rom
    assign sine_rom[j] = TWIDDLE_BITS'(rfft_pkg::sine_value(j, TW_LOG2, TW_FRAC));
  end

  always_comb begin
    tw_full = TW_LOG2'(bf & lo_mask) << (TW_LOG2 - 1 - int'(st));
    tw_idx  = tw_full[RA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (int'(tw_idx) <= TW_Q) begin
      tw_c <= signed'({1'b0, sine_rom[RA_W'(TW_Q - int'(tw_idx))]});
      tw_s <= signed'({1'b0, sine_rom[tw_idx]});
    end else begin
      tw_c <= -signed'({1'b0, sine_rom[RA_W'(int'(tw_idx) - TW_Q)]});
      tw_s <= signed'({1'b0, sine_rom[RA_W'(2 * TW_Q - int'(tw_idx))]});
    end
  end

  // ---------------- addressing ----------------
  always_comb begin
    lo_mask = (MX'(1) << st) - MX'(1);
    bi      = ((bf >> st) << (st + LGW'(1))) | (bf & lo_mask);
    bk      = bi | (MX'(1) << st);
    n_cfg   = (MX + 1)'(1) << lg;
    n_fr    = (MX + 1)'(1) << fr_lg;
    half_m1 = MX'((n_fr >> 1) - (MX + 1)'(1));
    last_bf = (bf == half_m1);
    last_st = (st == fr_lg - LGW'(1));
    ld_pos  = load_count[MX-1:0];
    for (int b = 0; b < MX; b++) rev[b] = ld_pos[MX-1-b];
    rev     = rev >> (MX - int'(lg));
  end

  assign q_pop      = (state == S_IDLE) && q_ctl.valid && !emit_pend
                      && (!out_valid || out_ch.ready);
  assign do_read    = q_pop && (pending != '0);
  assign do_load    = q_pop && q_ctl.load;
  assign frame_done = do_load && (load_count + (MX + 1)'(1) == n_cfg);

  // ---------------- butterfly datapath ----------------
  logic signed [WB-1:0]  a_re, a_im, b_re, b_im;
  logic signed [WB-1:0]  sa_re, sa_im;
  logic [LGW-1:0]        sh;
  logic signed [TWW-1:0] wr, wi;
  logic signed [HI-1:0]  bh_re, bh_im;
  logic signed [LO:0]    bl_re, bl_im;
  logic signed [TWW+HI-1:0]  p_rr_h, p_ii_h, p_ri_h, p_ir_h;
  logic signed [TWW+LO:0]    p_rr_l, p_ii_l, p_ri_l, p_ir_l;
  logic signed [63:0]    pr, pi, tr_full, ti_full;
  logic signed [WB-1:0]  tr, ti;

  always_comb begin
    sh    = ((st == '0) && !fr_dir) ? fr_lg : '0;
    sa_re = signed'(rd_a[2*WB-1:WB]) >>> sh;
    sa_im = signed'(rd_a[WB-1:0]) >>> sh;
    b_re  = signed'(rd_b[2*WB-1:WB]) >>> sh;
    b_im  = signed'(rd_b[WB-1:0]) >>> sh;
    bh_re = b_re[WB-1:LO];
    bh_im = b_im[WB-1:LO];
    bl_re = signed'({1'b0, b_re[LO-1:0]});
    bl_im = signed'({1'b0, b_im[LO-1:0]});
    wr    = tw_c;
    wi    = fr_dir ? tw_s : -tw_s;
    pr = (64'(p_rr_h) <<< LO) + 64'(p_rr_l) - (64'(p_ii_h) <<< LO) - 64'(p_ii_l)
         + (64'sd1 <<< (TW_FRAC - 1));
    pi = (64'(p_ri_h) <<< LO) + 64'(p_ri_l) + (64'(p_ir_h) <<< LO) + 64'(p_ir_l)
         + (64'sd1 <<< (TW_FRAC - 1));
    tr_full = pr >>> TW_FRAC;
    ti_full = pi >>> TW_FRAC;
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      a_re   <= sa_re;
      a_im   <= sa_im;
      p_rr_h <= wr * bh_re;
      p_rr_l <= wr * bl_re;
      p_ii_h <= wi * bh_im;
      p_ii_l <= wi * bl_im;
      p_ri_h <= wr * bh_im;
      p_ri_l <= wr * bl_im;
      p_ir_h <= wi * bh_re;
      p_ir_l <= wi * bl_re;
    end
    if (state == S_SUM) begin
      tr <= tr_full[WB-1:0];
      ti <= ti_full[WB-1:0];
    end
  end

  // ---------------- memory port muxing ----------------
  always_comb begin
    mem_we    = do_load || (state == S_WA) || (state == S_WB);
    mem_waddr = {wb, bk};
    mem_wdata = {a_re - tr, a_im - ti};
    if (do_load) begin
      mem_waddr = {wb, rev};
      mem_wdata = {WB'(q_re) << FB, WB'(q_im) << FB};
    end else if (state == S_WA) begin
      mem_waddr = {wb, bi};
      mem_wdata = {a_re + tr, a_im + ti};
    end
    raddr_a = (state == S_IDLE) ? {res_bank, read_index} : {wb, bi};
    raddr_b = {wb, bk};
  end

  // ---------------- control ----------------
  always_comb begin
    cfg_lg = LGW'(cfg_wdata);
    if (cfg_wdata == '0)                      cfg_lg = LGW'(1);
    else if (int'(cfg_wdata) > MX)            cfg_lg = LGW'(MX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      lg         <= LGW'(LG_RST);
      dir        <= 1'b0;
      fr_lg      <= LGW'(1);
      fr_dir     <= 1'b0;
      wb         <= 1'b0;
      res_bank   <= 1'b1;
      load_count <= '0;
      read_index <= '0;
      pending    <= '0;
      st         <= '0;
      bf         <= '0;
      emit_pend  <= 1'b0;
    end else begin
      emit_pend <= do_read;
      unique case (state)
        S_IDLE: begin
          if (do_read) begin
            pending    <= pending - (MX + 1)'(1);
            read_index <= (pending == (MX + 1)'(1)) ? '0 : read_index + MX'(1);
          end
          if (do_load) load_count <= load_count + (MX + 1)'(1);
          if (frame_done) begin
            load_count <= '0;
            fr_lg      <= lg;
            fr_dir     <= dir;
            st         <= '0;
            bf         <= '0;
            state      <= S_RD;
          end
        end
        S_RD:  state <= S_MUL;
        S_MUL: state <= S_SUM;
        S_SUM: state <= S_WA;
        S_WA:  state <= S_WB;
        S_WB: begin
          state <= S_RD;
          if (last_bf) begin
            bf <= '0;
            if (last_st) begin
              state      <= S_IDLE;
              res_bank   <= wb;
              wb         <= ~wb;
              pending    <= n_fr;
              read_index <= '0;
              st         <= '0;
            end else begin
              st <= st + LGW'(1);
            end
          end else begin
            bf <= bf + MX'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          rfft_pkg::CFG_LOG2_LENGTH: begin
            lg         <= cfg_lg;
            load_count <= '0;
          end
          rfft_pkg::CFG_DIRECTION: dir <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- output register ----------------
  logic signed [WB:0]      rnd_re, rnd_im;
  logic signed [SAT_W-1:0] x_re, x_im, sat_hi, sat_lo;
  logic signed [OB-1:0]    o_re, o_im;

  always_comb begin
    rnd_re = (WB + 1)'(signed'(rd_a[2*WB-1:WB])) + ((WB + 1)'(1) <<< (FB - 1));
    rnd_im = (WB + 1)'(signed'(rd_a[WB-1:0])) + ((WB + 1)'(1) <<< (FB - 1));
    x_re   = SAT_W'(signed'(rnd_re[WB:FB]));
    x_im   = SAT_W'(signed'(rnd_im[WB:FB]));
    sat_hi = signed'(SAT_W'({1'b0, {(OB - 1){1'b1}}}));
    sat_lo = -sat_hi - SAT_W'(1);
    o_re   = OB'(x_re);
    o_im   = OB'(x_im);
    if (x_re > sat_hi) o_re = OB'(sat_hi);
    if (x_re < sat_lo) o_re = OB'(sat_lo);
    if (x_im > sat_hi) o_im = OB'(sat_hi);
    if (x_im < sat_lo) o_im = OB'(sat_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_pend) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      emit_idx  <= read_index;
      emit_last <= (pending == (MX + 1)'(1));
    end
    if (emit_pend) begin
      out_ch.real_out  <= o_re;
      out_ch.imag_out  <= o_im;
      out_ch.bin_index <= emit_idx;
      out_ch.last_out  <= emit_last;
    end
  end

  assign out_ch.valid = out_valid;

  `RFFT_CHECK(a_banks_apart, res_bank != wb, "result bank and work bank coincide")
  `RFFT_CHECK_NEXT(a_emit_fills, emit_pend, out_valid, "read result not presented")
  `RFFT_CHECK(a_idle_index, (pending == '0) |-> (read_index == '0), "read index not rewound")
  `RFFT_CHECK_NEXT(a_frame_end, (state == S_WB) && last_bf && last_st,
                   (state == S_IDLE) && (pending != '0), "transform end did not publish")

endmodule

// ===== rtl/radix2_complex_fft.sv =====
// fft top level: front queue plus transform back end
// result path: a bin read by an item leaving the 2-entry queue passes the memory read
//   register, then the output register; the next item waits until that read reaches
//   the output register, and a full output register that is not taken stalls every item
// a frame's last load starts a transform of (N/2) * log2(N) butterflies, one at a time
//   through the single read, multiply, add, write pass; the queue is not popped meanwhile
// reset: length 10, forward, empty queue, nothing pending; sample memory has no reset value
module radix2_complex_fft #(
  parameter int MAX_LOG2_LENGTH = rfft_pkg::MAX_LOG2_LENGTH,
  parameter int SAMPLE_BITS     = rfft_pkg::SAMPLE_BITS,
  parameter int TWIDDLE_BITS    = rfft_pkg::TWIDDLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  rfft_in_if.sink                             in_ch,
  rfft_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [rfft_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rfft_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  // queue handshake between the two halves
  rfft_pkg::queue_ctl_t          q_ctl;
  logic signed [SAMPLE_BITS-1:0] q_re;
  logic signed [SAMPLE_BITS-1:0] q_im;
  logic                          q_pop;

  // front: accepts items and buffers them, so the source keeps going
  // while the back end works on the previous item
  rfft_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .q_ctl (q_ctl),
    .q_re  (q_re),
    .q_im  (q_im),
    .q_pop (q_pop)
  );

  // back: on each item reads one pending bin if any, stores a load item's sample at its
  // bit-reversed place, and after the last sample of a frame runs the
  // in-place butterflies; finished frames swap banks so the old results
  // stay readable until the new transform is done
  rfft_back #(
    .MAX_LOG2_LENGTH (MAX_LOG2_LENGTH),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .TWIDDLE_BITS    (TWIDDLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_ctl     (q_ctl),
    .q_re      (q_re),
    .q_im      (q_im),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench of the radix-2 fft: scoreboard class, drivers, monitors
`timescale 1ns / 1ps

typedef struct {
  logic signed [26:0] re;
  logic signed [26:0] im;
  logic [9:0]         bin;
  logic               last;
} fft_bin_t;

class fft_scoreboard;
  longint   work_re[1024];
  longint   work_im[1024];
  longint   bins_re[1024];
  longint   bins_im[1024];
  longint   sine_q17[257];
  int       lg;
  int       dir;
  int       load_cnt;
  int       rd_idx;
  int       pending;
  int       busy_cycles;
  int       errors;
  fft_bin_t bin_q[$];

  function new();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          s;
    longint unsigned q;
    lg = 10;
    dir = 0;
    load_cnt = 0;
    rd_idx = 0;
    pending = 0;
    busy_cycles = 0;
    errors = 0;
    // quarter-wave sine table, taylor series in q30 rounded to 17 fraction bits
    for (int j = 0; j <= 256; j++) begin
      x = (rfft_pkg::PI2_Q30 * longint'(j) + 64'd512) >> 10;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      s = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2 + (64'd1 << 29)) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s = s - longint'(term);
        else s = s + longint'(term);
      end
      if (s < 0) s = 0;
      q = longint'(s);
      sine_q17[j] = longint'((q + (64'd1 << 12)) >> 13);
    end
  endfunction

  function longint wrap48(longint v);
    logic signed [47:0] t;
    t = v[47:0];
    return longint'(t);
  endfunction

  function logic signed [26:0] to_sample(longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd67108863) r = 64'sd67108863;
    if (r < -64'sd67108864) r = -64'sd67108864;
    return r[26:0];
  endfunction

  function void write_cfg(logic idx, logic [3:0] val);
    if (idx == rfft_pkg::CFG_LOG2_LENGTH) begin
      lg = (val < 1) ? 1 : ((val > 10) ? 10 : int'(val));
      load_cnt = 0;
    end else begin
      dir = int'(val[0]);
    end
  endfunction

  function void run_transform();
    int     n;
    int     j;
    int     half;
    int     tw;
    longint c;
    longint sn;
    longint wi;
    longint br;
    longint bi;
    longint tr;
    longint ti;
    longint t;
    n = 1 << lg;
    // forward frames are scaled by 1/n with a floor shift
    if (dir == 0) begin
      for (int i = 0; i < n; i++) begin
        work_re[i] = work_re[i] >>> lg;
        work_im[i] = work_im[i] >>> lg;
      end
    end
    for (int i = 0; i < n; i++) begin
      j = 0;
      for (int b = 0; b < lg; b++) j |= ((i >> b) & 1) << (lg - 1 - b);
      if (j > i) begin
        t = work_re[i]; work_re[i] = work_re[j]; work_re[j] = t;
        t = work_im[i]; work_im[i] = work_im[j]; work_im[j] = t;
      end
    end
    for (int st = 0; st < lg; st++) begin
      half = 1 << st;
      for (int m = 0; m < half; m++) begin
        tw = (m << (9 - st)) & 511;
        if (tw <= 256) begin
          c = sine_q17[256 - tw];
          sn = sine_q17[tw];
        end else begin
          c = -sine_q17[tw - 256];
          sn = sine_q17[512 - tw];
        end
        wi = dir ? sn : -sn;
        for (int i = m; i + half < n; i += 2 * half) begin
          br = work_re[i + half];
          bi = work_im[i + half];
          // whole cross sum, rounded once to nearest
          tr = (c * br - wi * bi + 64'sd65536) >>> 17;
          ti = (c * bi + wi * br + 64'sd65536) >>> 17;
          work_re[i + half] = wrap48(work_re[i] - tr);
          work_im[i + half] = wrap48(work_im[i] - ti);
          work_re[i] = wrap48(work_re[i] + tr);
          work_im[i] = wrap48(work_im[i] + ti);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      bins_re[i] = work_re[i];
      bins_im[i] = work_im[i];
    end
    pending = n;
    rd_idx = 0;
    busy_cycles = 5 * (n / 2) * lg + 20;
  endfunction

  // accepted input item: read a pending bin first, then take the sample
  function void note_input(logic act, logic signed [15:0] re, logic signed [15:0] im);
    fft_bin_t e;
    if (pending > 0) begin
      e.re = to_sample(bins_re[rd_idx]);
      e.im = to_sample(bins_im[rd_idx]);
      e.bin = rd_idx[9:0];
      e.last = (pending == 1);
      bin_q.push_back(e);
      pending--;
      rd_idx = pending ? rd_idx + 1 : 0;
    end
    if (act == rfft_pkg::ACT_LOAD) begin
      work_re[load_cnt] = longint'(re) * 65536;
      work_im[load_cnt] = longint'(im) * 65536;
      load_cnt++;
      if (load_cnt >= (1 << lg)) begin
        run_transform();
        load_cnt = 0;
      end
    end
  endfunction

  function void check_bin(logic signed [26:0] re, logic signed [26:0] im,
                          logic [9:0] bin, logic last);
    fft_bin_t e;
    if (bin_q.size() == 0) begin
      $display("%0t: unexpected bin re %0d im %0d bin %0d", $realtime, re, im, bin);
      errors++;
      return;
    end
    e = bin_q.pop_front();
    if (re !== e.re) begin
      $display("%0t: real_out expected %0d actual %0d", $realtime, e.re, re);
      errors++;
    end
    if (im !== e.im) begin
      $display("%0t: imag_out expected %0d actual %0d", $realtime, e.im, im);
      errors++;
    end
    if (bin !== e.bin) begin
      $display("%0t: bin_index expected %0d actual %0d", $realtime, e.bin, bin);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t: last_out expected %0d actual %0d", $realtime, e.last, last);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1450;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [3:0] cfg_wdata;

  // idle percentages of sender and receiver, and the long receiver hold-off
  int         tx_idle;
  int         rx_idle;
  bit         hold_req;
  int         sent;
  longint     cycles;

  fft_scoreboard sb = new();

  rfft_in_if  in_ch();
  rfft_out_if out_ch();

  radix2_complex_fft uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // monitors: items are taken at the rising edge with valid and ready high
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.action, in_ch.real_in, in_ch.imag_in);
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_bin(out_ch.real_out, out_ch.imag_out, out_ch.bin_index, out_ch.last_out);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold == 0) begin
        hold = 400;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // one item, entered at a falling edge; returns at the falling edge after
  // acceptance, where the next call or stop_sending drives valid
  task automatic send_item(logic act, logic signed [15:0] re, logic signed [15:0] im);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= 1'($urandom_range(1));
      in_ch.real_in <= 16'($urandom);
      in_ch.imag_in <= 16'($urandom);
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.real_in <= re;
    in_ch.imag_in <= im;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  // sender goes quiet: valid is dropped
  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load(logic signed [15:0] re, logic signed [15:0] im);
    send_item(rfft_pkg::ACT_LOAD, re, im);
  endtask

  task automatic drain_all();
    while (sb.pending > 0) send_item(rfft_pkg::ACT_DRAIN, 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_results();
    stop_sending();
    while (sb.bin_q.size() != 0) @(negedge clk);
  endtask

  // block idle: no bin owed, and any transform or queued load given time to finish
  task automatic settle();
    wait_results();
    repeat (sb.busy_cycles + 20) @(negedge clk);
    sb.busy_cycles = 0;
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_cfg(idx, val);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    int lg;
    bit paused;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = 4'd0;
    in_ch.valid = 1'b0;
    in_ch.action = rfft_pkg::ACT_LOAD;
    in_ch.real_in = '0;
    in_ch.imag_in = '0;
    tx_idle = 0;
    rx_idle = 0;
    hold_req = 1'b0;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // drain with nothing pending gives no bin
    send_item(rfft_pkg::ACT_DRAIN, 16'sh7fff, 16'sh8000);
    settle();

    // shortest forward frame with extreme samples
    write_reg(rfft_pkg::CFG_DIRECTION, 4'd0);
    write_reg(rfft_pkg::CFG_LOG2_LENGTH, 4'd1);
    load(16'sh7fff, 16'sh8000);
    load(16'sh8000, 16'sh7fff);
    drain_all();
    settle();

    // length zero acts as one, inverse unscaled
    write_reg(rfft_pkg::CFG_LOG2_LENGTH, 4'd0);
    write_reg(rfft_pkg::CFG_DIRECTION, 4'd1);
    load(16'sh8000, 16'sh8000);
    load(16'sh7fff, 16'sh7fff);
    drain_all();
    settle();

    // oversized length clamps, partial frame then discarded by a length write
    write_reg(rfft_pkg::CFG_LOG2_LENGTH, 4'd15);
    write_reg(rfft_pkg::CFG_LOG2_LENGTH, 4'd10);
    load(16'sh1234, -16'sh0321);
    load(16'sh8000, 16'sh7fff);
    load(16'sh0001, 16'shffff);
    settle();

    // new frame over old: bins left pending, shorter frame loaded on top
    write_reg(rfft_pkg::CFG_LOG2_LENGTH, 4'd2);
    write_reg(rfft_pkg::CFG_DIRECTION, 4'd0);
    load(16'sh7fff, 16'sh0000);
    load(16'sh0000, 16'sh7fff);
    load(16'sh8000, 16'sh0000);
    load(16'sh0000, 16'sh8000);
    settle();
    write_reg(rfft_pkg::CFG_LOG2_LENGTH, 4'd1);
    load(16'sh0100, 16'sh0200);
    load(-16'sh0100, 16'sh0300);
    drain_all();
    send_item(rfft_pkg::ACT_DRAIN, 16'sh0000, 16'sh0000);
    settle();

    // random part, three idle patterns in turn
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case (sent * 3 / RANDOM_ITEMS)
        0: begin tx_idle = 28; rx_idle = 73; end
        1: begin tx_idle = 73; rx_idle = 28; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      settle();
      lg = ($urandom_range(15) == 0) ? 7 : int'($urandom_range(1, 5));
      n = 1 << lg;
      write_reg(rfft_pkg::CFG_LOG2_LENGTH, lg[3:0]);
      write_reg(rfft_pkg::CFG_DIRECTION, 4'($urandom_range(1)));
      if (tx_idle == 0 && rx_idle == 0 && !hold_req && sent > 1200) hold_req = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(9) == 0)
            send_item(rfft_pkg::ACT_DRAIN, 16'($urandom), 16'($urandom));
          load(rand_sample(), rand_sample());
          // sender pause until every owed bin is out
          if (!paused && sent > 700) begin
            paused = 1'b1;
            wait_results();
          end
        end
      end
      // sometimes leave a partial frame for the next length write to discard
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(1, n - 1 > 0 ? n - 1 : 1)) load(rand_sample(), rand_sample());
      end
      drain_all();
    end

    wait_results();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.bin_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
